// ----- src/validated_time_sync_keeper_macros.svh -----
// Assertion macros for the time sync keeper.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef VALIDATED_TIME_SYNC_KEEPER_MACROS_SVH
`define VALIDATED_TIME_SYNC_KEEPER_MACROS_SVH

// same-cycle implication
`define VTSK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VTSK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/vtsk_pkg.sv -----
// Shared types and constants of the time sync keeper.
// No dependencies.
`timescale 1ns / 1ps

package vtsk_pkg;

  localparam int RING_DEPTH  = 8;
  localparam int TIME_W      = 48;
  localparam int CMD_W       = 3;
  localparam int SRC_W       = 8;
  localparam int EIDX_W      = 3;
  localparam int CNT_W       = $clog2(RING_DEPTH + 1);
  localparam int IDX_W       = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W   = 2;

  localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SYNC    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RBEGIN  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RRECORD = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_EPOCH_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EPOCH_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLACK     = 2'd2;

  localparam logic [TIME_W-1:0] EPOCH_MIN_RST = 48'd1577836800000;
  localparam logic [TIME_W-1:0] EPOCH_MAX_RST = 48'd4102444800000;
  localparam logic [TIME_W-1:0] SLACK_RST     = 48'd5000;

  typedef enum logic [2:0] {
    K_QUERY   = 3'd0,
    K_SYNC    = 3'd1,
    K_RBEGIN  = 3'd2,
    K_RRECORD = 3'd3,
    K_READ    = 3'd4,
    K_NONE    = 3'd5
  } kind_e;

  typedef struct packed {
    logic [TIME_W-1:0] epoch_min;
    logic [TIME_W-1:0] epoch_max;
    logic [TIME_W-1:0] slack;
  } cfg_t;

  typedef struct packed {
    kind_e              kind;
    logic               plausible;
    logic [TIME_W-1:0]  epoch;
    logic [TIME_W-1:0]  uptime;
    logic [SRC_W-1:0]   source;
    logic [EIDX_W-1:0]  index;
    logic               last;
    logic               clr;
  } item_t;

  typedef struct packed {
    logic               accepted;
    logic [TIME_W-1:0]  outage;
    logic [TIME_W-1:0]  now;
    logic               clock_valid;
    logic [TIME_W-1:0]  last_sync;
    logic [TIME_W-1:0]  last_known;
    logic [TIME_W-1:0]  boot_outage;
    logic [CNT_W-1:0]   count;
    logic [TIME_W-1:0]  ent_epoch;
    logic [TIME_W-1:0]  ent_uptime;
    logic [SRC_W-1:0]   ent_source;
    logic               dirty;
  } res_t;

endpackage

// ----- src/vtsk_if.sv -----
// Channel interfaces of the time sync keeper: command items in, status items out.
// Depends on vtsk_pkg.
`timescale 1ns / 1ps

interface vtsk_in_if;
  import vtsk_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [TIME_W-1:0]   epoch;
  logic [TIME_W-1:0]   uptime;
  logic [SRC_W-1:0]    source_id;
  logic [EIDX_W-1:0]   entry_index;
  logic                restore_last;
  logic                clear_dirty;

  modport source (output valid, command, epoch, uptime, source_id, entry_index,
                  restore_last, clear_dirty, input ready);
  modport sink   (input valid, command, epoch, uptime, source_id, entry_index,
                  restore_last, clear_dirty, output ready);
endinterface

interface vtsk_out_if;
  import vtsk_pkg::*;
  logic                valid;
  logic                ready;
  logic                accepted;
  logic [TIME_W-1:0]   outage;
  logic [TIME_W-1:0]   now_ms;
  logic                clock_valid;
  logic [TIME_W-1:0]   last_sync_ms;
  logic [TIME_W-1:0]   last_known_ms;
  logic [TIME_W-1:0]   boot_outage_ms;
  logic [CNT_W-1:0]    entry_count;
  logic [TIME_W-1:0]   entry_epoch_ms;
  logic [TIME_W-1:0]   entry_uptime_ms;
  logic [SRC_W-1:0]    entry_source;
  logic                dirty;

  modport source (output valid, accepted, outage, now_ms, clock_valid, last_sync_ms,
                  last_known_ms, boot_outage_ms, entry_count, entry_epoch_ms,
                  entry_uptime_ms, entry_source, dirty, input ready);
  modport sink   (input valid, accepted, outage, now_ms, clock_valid, last_sync_ms,
                  last_known_ms, boot_outage_ms, entry_count, entry_epoch_ms,
                  entry_uptime_ms, entry_source, dirty, output ready);
endinterface

// ----- src/vtsk_front.sv -----
// Front end: accepts command items, decodes the command and checks the epoch window.
// Depends on vtsk_pkg and vtsk_in_if.
`timescale 1ns / 1ps

module vtsk_front (
  vtsk_in_if.sink         in_i,
  input  vtsk_pkg::cfg_t  cfg_i,
  input  logic            full_i,
  output logic            push_o,
  output vtsk_pkg::item_t item_o
);
  import vtsk_pkg::*;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    case (in_i.command)
      CMD_QUERY:   item_o.kind = K_QUERY;
      CMD_SYNC:    item_o.kind = K_SYNC;
      CMD_RBEGIN:  item_o.kind = K_RBEGIN;
      CMD_RRECORD: item_o.kind = K_RRECORD;
      CMD_READ:    item_o.kind = K_READ;
      default:     item_o.kind = K_NONE;
    endcase
    item_o.plausible = (in_i.epoch >= cfg_i.epoch_min) && (in_i.epoch < cfg_i.epoch_max);
    item_o.epoch     = in_i.epoch;
    item_o.uptime    = in_i.uptime;
    item_o.source    = in_i.source_id;
    item_o.index     = in_i.entry_index;
    item_o.last      = in_i.restore_last;
    item_o.clr       = in_i.clear_dirty;
  end

endmodule

// ----- src/vtsk_queue.sv -----
// Short queue of decoded items between front and back.
// Depends on vtsk_pkg.
`timescale 1ns / 1ps

module vtsk_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  vtsk_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output vtsk_pkg::item_t item_o
);
  import vtsk_pkg::*;

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? QPTR_W'(wr_ptr_q + QPTR_W'(1)) : wr_ptr_q;
    rd_ptr_d = pop_i  ? QPTR_W'(rd_ptr_q + QPTR_W'(1)) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ----- src/vtsk_back.sv -----
// Back end: config registers, clock state, history ring and the status output register.
// Depends on vtsk_pkg, vtsk_out_if and validated_time_sync_keeper_macros.svh.
`timescale 1ns / 1ps

module vtsk_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [vtsk_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [vtsk_pkg::TIME_W-1:0]    cfg_wdata_i,
  output vtsk_pkg::cfg_t                 cfg_o,
  input  logic                           q_valid_i,
  input  vtsk_pkg::item_t                item_i,
  output logic                           pop_o,
  vtsk_out_if.source                     out_o
);
  import vtsk_pkg::*;
  `include "validated_time_sync_keeper_macros.svh"

  cfg_t              cfg_q, cfg_d;
  logic [TIME_W-1:0] base_q, base_d, last_q, last_d, boot_q, boot_d;
  logic              clkset_q, clkset_d, dirty_q, dirty_d, first_q, first_d, rok_q, rok_d;
  logic [CNT_W-1:0]  count_q, count_d, rptr_q, rptr_d;
  logic              out_valid_q, out_valid_d;
  res_t              res_q, res_d;

  logic [TIME_W-1:0] ring_e_q [RING_DEPTH];
  logic [TIME_W-1:0] ring_u_q [RING_DEPTH];
  logic [SRC_W-1:0]  ring_s_q [RING_DEPTH];

  logic              shift_en, wr_en, back_bad, sync_ok, acc;
  logic [IDX_W-1:0]  wr_addr, rd_addr;
  logic [TIME_W-1:0] lk, gap;

  assign pop_o   = q_valid_i && (!out_valid_q || out_o.ready);
  assign cfg_o   = cfg_q;
  assign wr_addr = rptr_q[IDX_W-1:0];
  assign rd_addr = IDX_W'(item_i.index);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_EPOCH_MIN: cfg_d.epoch_min = cfg_wdata_i;
        CFG_EPOCH_MAX: cfg_d.epoch_max = cfg_wdata_i;
        CFG_SLACK:     cfg_d.slack     = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    base_d   = base_q;
    last_d   = last_q;
    boot_d   = boot_q;
    clkset_d = clkset_q;
    dirty_d  = dirty_q;
    first_d  = first_q;
    rok_d    = rok_q;
    count_d  = count_q;
    rptr_d   = rptr_q;
    shift_en = 1'b0;
    wr_en    = 1'b0;
    acc      = 1'b0;
    gap      = '0;
    res_d    = res_q;

    lk       = (count_q != '0) ? ring_e_q[0] : '0;
    back_bad = (lk != '0) && (lk > item_i.epoch) && ((lk - item_i.epoch) > cfg_q.slack);
    sync_ok  = item_i.plausible && !back_bad;

    res_d.ent_epoch  = '0;
    res_d.ent_uptime = '0;
    res_d.ent_source = '0;

    case (item_i.kind)
      K_QUERY: begin
        if (item_i.clr) begin
          dirty_d = 1'b0;
        end
      end
      K_SYNC: begin
        if (sync_ok) begin
          acc      = 1'b1;
          gap      = ((lk != '0) && (item_i.epoch > lk)) ? item_i.epoch - lk : '0;
          if (!first_q) begin
            boot_d  = gap;
            first_d = 1'b1;
          end
          shift_en = 1'b1;
          count_d  = (count_q < CNT_W'(RING_DEPTH)) ? count_q + CNT_W'(1) : CNT_W'(RING_DEPTH);
          base_d   = item_i.epoch - item_i.uptime;
          last_d   = item_i.epoch;
          clkset_d = 1'b1;
          dirty_d  = 1'b1;
          rok_d    = 1'b0;
        end
      end
      K_RBEGIN: begin
        count_d = '0;
        rptr_d  = '0;
        rok_d   = 1'b1;
      end
      K_RRECORD: begin
        if (rok_q) begin
          if ((rptr_q >= CNT_W'(RING_DEPTH)) || !item_i.plausible) begin
            count_d = '0;
            rok_d   = 1'b0;
          end else begin
            wr_en  = 1'b1;
            acc    = 1'b1;
            rptr_d = rptr_q + CNT_W'(1);
            if (item_i.last) begin
              count_d = rptr_q + CNT_W'(1);
              rok_d   = 1'b0;
            end
          end
        end
      end
      K_READ: begin
        if ((int'(item_i.index) < int'(count_q)) && (int'(item_i.index) < RING_DEPTH)) begin
          res_d.ent_epoch  = ring_e_q[rd_addr];
          res_d.ent_uptime = ring_u_q[rd_addr];
          res_d.ent_source = ring_s_q[rd_addr];
        end
      end
      default: ;
    endcase

    res_d.accepted    = acc;
    res_d.outage      = gap;
    res_d.clock_valid = clkset_d;
    if (!clkset_d) begin
      res_d.now = '0;
    end else if (shift_en) begin
      res_d.now = item_i.epoch;
    end else begin
      res_d.now = base_q + item_i.uptime;
    end
    res_d.last_sync   = last_d;
    if (shift_en) begin
      res_d.last_known = item_i.epoch;
    end else if (count_d == '0) begin
      res_d.last_known = '0;
    end else if (wr_en && (wr_addr == '0)) begin
      res_d.last_known = item_i.epoch;
    end else begin
      res_d.last_known = ring_e_q[0];
    end
    res_d.boot_outage = boot_d;
    res_d.count       = count_d;
    res_d.dirty       = (item_i.kind == K_QUERY) ? dirty_q : dirty_d;

    out_valid_d = pop_o ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.epoch_min <= EPOCH_MIN_RST;
      cfg_q.epoch_max <= EPOCH_MAX_RST;
      cfg_q.slack     <= SLACK_RST;
      base_q      <= '0;
      last_q      <= '0;
      boot_q      <= '0;
      clkset_q    <= 1'b0;
      dirty_q     <= 1'b0;
      first_q     <= 1'b0;
      rok_q       <= 1'b0;
      count_q     <= '0;
      rptr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        base_q   <= base_d;
        last_q   <= last_d;
        boot_q   <= boot_d;
        clkset_q <= clkset_d;
        dirty_q  <= dirty_d;
        first_q  <= first_d;
        rok_q    <= rok_d;
        count_q  <= count_d;
        rptr_q   <= rptr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
      if (shift_en) begin
        for (int i = 1; i < RING_DEPTH; i++) begin
          ring_e_q[i] <= ring_e_q[i-1];
          ring_u_q[i] <= ring_u_q[i-1];
          ring_s_q[i] <= ring_s_q[i-1];
        end
        ring_e_q[0] <= item_i.epoch;
        ring_u_q[0] <= item_i.uptime;
        ring_s_q[0] <= item_i.source;
      end else if (wr_en) begin
        ring_e_q[wr_addr] <= item_i.epoch;
        ring_u_q[wr_addr] <= '0;
        ring_s_q[wr_addr] <= item_i.source;
      end
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.accepted        = res_q.accepted;
  assign out_o.outage          = res_q.outage;
  assign out_o.now_ms          = res_q.now;
  assign out_o.clock_valid     = res_q.clock_valid;
  assign out_o.last_sync_ms    = res_q.last_sync;
  assign out_o.last_known_ms   = res_q.last_known;
  assign out_o.boot_outage_ms  = res_q.boot_outage;
  assign out_o.entry_count     = res_q.count;
  assign out_o.entry_epoch_ms  = res_q.ent_epoch;
  assign out_o.entry_uptime_ms = res_q.ent_uptime;
  assign out_o.entry_source    = res_q.ent_source;
  assign out_o.dirty           = res_q.dirty;

  `VTSK_ASSERT_NOW(a_count_range, 1'b1, (count_q <= CNT_W'(RING_DEPTH)) && (rptr_q <= CNT_W'(RING_DEPTH)), "ring count or restore pointer beyond depth")
  `VTSK_ASSERT_NEXT(a_sync_sets_clock, pop_o && (item_i.kind == K_SYNC) && sync_ok, clkset_q && dirty_q && !rok_q && first_q, "accepted sync did not update state")
  `VTSK_ASSERT_NEXT(a_restore_begin, pop_o && (item_i.kind == K_RBEGIN), rok_q && (count_q == '0) && (rptr_q == '0), "restore begin did not open restore")
  `VTSK_ASSERT_NEXT(a_result_after_pop, pop_o, out_valid_q && (out_o.entry_count == count_q), "popped item left no result")

endmodule

// ----- src/validated_time_sync_keeper.sv -----
// Top level of the time sync keeper: front decode, item queue, back execute.
// Depends on vtsk_pkg, vtsk_if, vtsk_front, vtsk_queue and vtsk_back.
//
// channel   direction  handshake      contents
// in_i      sink       valid/ready    command item: command, epochs, source, index, flags
// out_o     source     valid/ready    status item, one per command item
// cfg       write      cfg_we_i       register index and 48-bit data, no read-back
//
// One item per cycle sustained while the output takes each result; the back executes each item combinationally.
// An accepted item is registered in the queue, then its result in the output register.
// While a result waits at the output the queue takes two more items, then the input stalls.
// Reset is ready at once: no clearing pass, ring entries are tracked by the entry count.
`timescale 1ns / 1ps

module validated_time_sync_keeper (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  vtsk_in_if.sink                        in_i,
  vtsk_out_if.source                     out_o,
  input  logic                           cfg_we_i,
  input  logic [vtsk_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [vtsk_pkg::TIME_W-1:0]    cfg_wdata_i
);
  import vtsk_pkg::*;

  cfg_t  cfg;
  item_t front_item, queue_item;
  logic  push, full, pop, q_valid;

  vtsk_front u_front (
    .in_i   (in_i),
    .cfg_i  (cfg),
    .full_i (full),
    .push_o (push),
    .item_o (front_item)
  );

  vtsk_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (queue_item)
  );

  vtsk_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .q_valid_i   (q_valid),
    .item_i      (queue_item),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule
